// ----- rtl/sth_pkg.sv -----
// ----------------------------------------------------------------------------
// sth_pkg
// shared widths, register map and result codes of the segment/triangle test
// ----------------------------------------------------------------------------
package sth_pkg;

    // coordinate and intermediate widths (exact, no rounding anywhere)
    localparam int COORD_W = 32;   // raw signed fixed-point coordinate
    localparam int DIFF_W  = 33;   // difference of two coordinates
    localparam int PROD_W  = 66;   // product of two differences
    localparam int CROSS_W = 67;   // cross product component
    localparam int SPLIT_W = 34;   // low part of a cross component
    localparam int HIGH_W  = CROSS_W - SPLIT_W;
    localparam int PLO_W   = DIFF_W + SPLIT_W + 1;
    localparam int TERM_W  = 100;  // one term of a triple product
    localparam int TRIP_W  = 102;  // triple product
    localparam int SUM_W   = 104;  // plane denominator
    localparam int THR_W   = 32;
    localparam int QID_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int NSTAGE  = 9;

    // register map, word index
    typedef enum logic [2:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5,
        REG_THRESH  = 3'd6,
        REG_QUERY   = 3'd7
    } t_reg_idx;

    // result reason codes
    typedef enum logic [2:0] {
        RSN_HIT      = 3'd0,
        RSN_BOX_MISS = 3'd1,
        RSN_PARALLEL = 3'd2,
        RSN_OUT_SEG  = 3'd3,
        RSN_OUT_TRI  = 3'd4
    } t_reason;

endpackage

// ----- rtl/segment_triangle_hit_test.sv -----
// ----------------------------------------------------------------------------
// segment_triangle_hit_test
// tests a configured line segment against a stream of triangles
// ----------------------------------------------------------------------------
// A new triangle is taken every clock cycle unless the pipeline stalls; each
// result passes the nine-stage arithmetic pipeline (differences and box test,
// 33x33 products, cross products, split 33x34 products, term, triple and
// denominator sums, magnitudes, final decision). The pipeline stalls stage
// by stage from the output side, so empty stages keep filling while a result
// waits. The user must write segment registers, threshold and query number
// over APB only while no triangle is in flight; the block does not check it.
// ----------------------------------------------------------------------------
module segment_triangle_hit_test #(
    parameter int INDEX_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sth_pkg::ADDR_W-1:0] paddr,
    input  logic [sth_pkg::DATA_W-1:0] pwdata,
    output logic [sth_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    // triangle requests
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tri_index, ax, ay, az, bx, by, bz, cx, cy, cz (lowest first), zero pad
    input  logic [((INDEX_WIDTH+9*sth_pkg::COORD_W+7)/8)*8-1:0] s_axis_tdata,
    input  logic                      s_axis_tlast,
    // result requests
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_tri_index, out_query_id (lowest first), zero pad
    output logic [((INDEX_WIDTH+sth_pkg::QID_W+7)/8)*8-1:0] m_axis_tdata,
    // hit, reason (lowest first)
    output logic [3:0]                m_axis_tuser,
    output logic                      m_axis_tlast
);

    localparam int OUT_W = ((INDEX_WIDTH + sth_pkg::QID_W + 7) / 8) * 8;
    localparam int CW    = sth_pkg::COORD_W;
    localparam int DW    = sth_pkg::DIFF_W;

    // configuration registers
    logic signed [CW-1:0]           r_start [3];
    logic signed [CW-1:0]           r_end   [3];
    logic [sth_pkg::THR_W-1:0]      r_thr;
    logic [sth_pkg::QID_W-1:0]      r_qid;
    sth_pkg::t_reg_idx              cfg_idx;

    assign cfg_idx = sth_pkg::t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_start[k] <= '0;
                r_end[k]   <= '0;
            end
            r_thr <= '0;
            r_qid <= '0;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                sth_pkg::REG_START_X: r_start[0] <= pwdata;
                sth_pkg::REG_START_Y: r_start[1] <= pwdata;
                sth_pkg::REG_START_Z: r_start[2] <= pwdata;
                sth_pkg::REG_END_X:   r_end[0]   <= pwdata;
                sth_pkg::REG_END_Y:   r_end[1]   <= pwdata;
                sth_pkg::REG_END_Z:   r_end[2]   <= pwdata;
                sth_pkg::REG_THRESH:  r_thr      <= pwdata;
                sth_pkg::REG_QUERY:   r_qid      <= pwdata[sth_pkg::QID_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (cfg_idx)
            sth_pkg::REG_START_X: prdata = r_start[0];
            sth_pkg::REG_START_Y: prdata = r_start[1];
            sth_pkg::REG_START_Z: prdata = r_start[2];
            sth_pkg::REG_END_X:   prdata = r_end[0];
            sth_pkg::REG_END_Y:   prdata = r_end[1];
            sth_pkg::REG_END_Z:   prdata = r_end[2];
            sth_pkg::REG_THRESH:  prdata = r_thr;
            sth_pkg::REG_QUERY:   prdata = {{(sth_pkg::DATA_W-sth_pkg::QID_W){1'b0}}, r_qid};
            default:              prdata = '0;
        endcase
    end

    // pipeline flow control: each stage loads when empty or draining
    logic                   r_vld  [1:sth_pkg::NSTAGE];
    logic                   rdy    [1:sth_pkg::NSTAGE];
    logic [INDEX_WIDTH-1:0] r_idx  [1:sth_pkg::NSTAGE];
    logic                   r_last [1:sth_pkg::NSTAGE];
    logic                   r_box  [1:sth_pkg::NSTAGE];

    always_comb begin
        rdy[sth_pkg::NSTAGE] = !r_vld[sth_pkg::NSTAGE] || m_axis_tready;
        for (int s = sth_pkg::NSTAGE - 1; s >= 1; s--)
            rdy[s] = !r_vld[s] || rdy[s+1];
    end

    assign s_axis_tready = rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= sth_pkg::NSTAGE; s++)
                r_vld[s] <= 1'b0;
        end else begin
            if (rdy[1])
                r_vld[1] <= s_axis_tvalid;
            for (int s = 2; s <= sth_pkg::NSTAGE; s++)
                if (rdy[s])
                    r_vld[s] <= r_vld[s-1];
        end
    end

    // sideband travels with the valid bits
    always_ff @(posedge i_clk) begin
        for (int s = 2; s <= sth_pkg::NSTAGE; s++) begin
            if (rdy[s]) begin
                r_idx[s]  <= r_idx[s-1];
                r_last[s] <= r_last[s-1];
                r_box[s]  <= r_box[s-1];
            end
        end
    end

    // stage 1: unpack, bounding box test, differences from segment start
    logic signed [CW-1:0] v [3][3];
    logic                 n_box;
    logic signed [DW-1:0] r1_d [3];
    logic signed [DW-1:0] r1_a [3][3];

    always_comb begin
        logic signed [CW-1:0] lo, hi, mn, mx;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                v[i][k] = s_axis_tdata[INDEX_WIDTH + CW*(3*i+k) +: CW];
        n_box = 1'b0;
        for (int k = 0; k < 3; k++) begin
            lo = (r_start[k] < r_end[k]) ? r_start[k] : r_end[k];
            hi = (r_start[k] < r_end[k]) ? r_end[k] : r_start[k];
            mn = (v[0][k] < v[1][k]) ? v[0][k] : v[1][k];
            mn = (mn < v[2][k]) ? mn : v[2][k];
            mx = (v[0][k] > v[1][k]) ? v[0][k] : v[1][k];
            mx = (mx > v[2][k]) ? mx : v[2][k];
            if (mx < lo || mn > hi)
                n_box = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_idx[1]  <= s_axis_tdata[INDEX_WIDTH-1:0];
            r_last[1] <= s_axis_tlast;
            r_box[1]  <= n_box;
            for (int k = 0; k < 3; k++) begin
                r1_d[k] <= {r_end[k][CW-1], r_end[k]} - {r_start[k][CW-1], r_start[k]};
                for (int i = 0; i < 3; i++)
                    r1_a[i][k] <= {v[i][k][CW-1], v[i][k]} - {r_start[k][CW-1], r_start[k]};
            end
        end
    end

    // stage 2: cross product partial products for pairs (a0,a1) (a1,a2) (a2,a0)
    logic signed [sth_pkg::PROD_W-1:0] r2_p [3][3][2];
    logic signed [DW-1:0]              r2_d [3];
    logic signed [DW-1:0]              r2_a0 [3];

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_p[c][k][0] <= r1_a[c][(k+1)%3] * r1_a[(c+1)%3][(k+2)%3];
                    r2_p[c][k][1] <= r1_a[c][(k+2)%3] * r1_a[(c+1)%3][(k+1)%3];
                end
            end
            r2_d  <= r1_d;
            r2_a0 <= r1_a[0];
        end
    end

    // stage 3: cross product components
    logic signed [sth_pkg::CROSS_W-1:0] r3_c [3][3];
    logic signed [DW-1:0]               r3_d [3];
    logic signed [DW-1:0]               r3_a0 [3];

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            for (int c = 0; c < 3; c++)
                for (int k = 0; k < 3; k++)
                    r3_c[c][k] <= r2_p[c][k][0] - r2_p[c][k][1];
            r3_d  <= r2_d;
            r3_a0 <= r2_a0;
        end
    end

    // stage 4: dot products split into high and low partial products
    // triples 0..2 are the edge products, triple 3 is the numerator
    logic signed [sth_pkg::PROD_W-1:0] r4_ph [4][3];
    logic signed [sth_pkg::PLO_W-1:0]  r4_pl [4][3];

    always_ff @(posedge i_clk) begin
        logic signed [DW-1:0]                 u;
        logic signed [sth_pkg::CROSS_W-1:0]   cv;
        if (rdy[4]) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    u  = (j == 3) ? r3_a0[k] : r3_d[k];
                    cv = (j == 3) ? r3_c[1][k] : r3_c[j][k];
                    r4_ph[j][k] <= u * $signed(cv[sth_pkg::CROSS_W-1:sth_pkg::SPLIT_W]);
                    r4_pl[j][k] <= u * $signed({1'b0, cv[sth_pkg::SPLIT_W-1:0]});
                end
            end
        end
    end

    // stage 5: recombine partial products
    logic signed [sth_pkg::TERM_W-1:0] r5_t [4][3];

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            for (int j = 0; j < 4; j++)
                for (int k = 0; k < 3; k++)
                    r5_t[j][k] <= $signed({r4_ph[j][k], {sth_pkg::SPLIT_W{1'b0}}})
                                  + r4_pl[j][k];
        end
    end

    // stage 6: triple products
    logic signed [sth_pkg::TRIP_W-1:0] r6_tr [4];

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            for (int j = 0; j < 4; j++)
                r6_tr[j] <= r5_t[j][0] + r5_t[j][1] + r5_t[j][2];
        end
    end

    // stage 7: denominator and edge signs
    logic signed [sth_pkg::SUM_W-1:0] r7_den;
    logic signed [sth_pkg::SUM_W-1:0] r7_num;
    logic [2:0]                       r7_tneg;
    logic [2:0]                       r7_tpos;

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r7_den <= r6_tr[0] + r6_tr[1] + r6_tr[2];
            r7_num <= r6_tr[3];
            for (int j = 0; j < 3; j++) begin
                r7_tneg[j] <= r6_tr[j][sth_pkg::TRIP_W-1];
                r7_tpos[j] <= !r6_tr[j][sth_pkg::TRIP_W-1] && (r6_tr[j] != '0);
            end
        end
    end

    // stage 8: magnitudes and signs
    logic [sth_pkg::SUM_W-1:0] r8_aden;
    logic [sth_pkg::SUM_W-1:0] r8_anum;
    logic                      r8_dneg;
    logic                      r8_nneg;
    logic                      r8_npos;
    logic [2:0]                r8_tneg;
    logic [2:0]                r8_tpos;

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r8_aden <= r7_den[sth_pkg::SUM_W-1] ? -r7_den : r7_den;
            r8_anum <= r7_num[sth_pkg::SUM_W-1] ? -r7_num : r7_num;
            r8_dneg <= r7_den[sth_pkg::SUM_W-1];
            r8_nneg <= r7_num[sth_pkg::SUM_W-1];
            r8_npos <= !r7_num[sth_pkg::SUM_W-1] && (r7_num != '0);
            r8_tneg <= r7_tneg;
            r8_tpos <= r7_tpos;
        end
    end

    // stage 9: decision, held as the output register
    sth_pkg::t_reason n_reason;
    sth_pkg::t_reason r9_reason;

    always_comb begin
        logic edge_out;
        edge_out = r8_dneg ? (|r8_tpos) : (|r8_tneg);
        if (r_box[8])
            n_reason = sth_pkg::RSN_BOX_MISS;
        else if (r8_aden <= {{(sth_pkg::SUM_W-sth_pkg::THR_W){1'b0}}, r_thr})
            n_reason = sth_pkg::RSN_PARALLEL;
        else if ((r8_dneg ? r8_npos : r8_nneg) || (r8_anum > r8_aden))
            n_reason = sth_pkg::RSN_OUT_SEG;
        else if (edge_out)
            n_reason = sth_pkg::RSN_OUT_TRI;
        else
            n_reason = sth_pkg::RSN_HIT;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[9])
            r9_reason <= n_reason;
    end

    // result port
    assign m_axis_tvalid = r_vld[sth_pkg::NSTAGE];
    assign m_axis_tlast  = r_last[sth_pkg::NSTAGE];
    assign m_axis_tuser  = {r9_reason, r9_reason == sth_pkg::RSN_HIT};
    assign m_axis_tdata  = OUT_W'({r_qid, r_idx[sth_pkg::NSTAGE]});

`ifndef SYNTHESIS
    // hit flag agrees with the reason code
    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[3:1] == sth_pkg::RSN_HIT)))
        else $error("hit flag disagrees with reason");

    // the input is held off only while the first stage is occupied
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_vld[1] && !rdy[2]))
        else $error("input stalled with room in the pipeline");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// ----- tb/tb_segment_triangle_hit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_triangle_hit_test
// self-checking bench for the segment/triangle hit test
// ----------------------------------------------------------------------------
// Programs a segment over APB, streams triangles through the input port in
// bursts and checks each result against the table or an exact wide predictor.
// A short directed table comes first, then random triangles, most of them
// built around points on or near the segment so that every reason code is hit.
// ----------------------------------------------------------------------------
module tb_segment_triangle_hit_test;

    localparam int IW      = 16;
    localparam int CW      = sth_pkg::COORD_W;
    localparam int QW      = sth_pkg::QID_W;
    localparam int AW      = sth_pkg::ADDR_W;
    localparam int IN_W    = ((IW + 9*CW + 7)/8)*8;
    localparam int OUT_W   = ((IW + QW + 7)/8)*8;
    localparam int LATENCY = sth_pkg::NSTAGE;
    localparam int WD_LIMIT = 20000;

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic [IW-1:0]        idx;
        logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic                 last;
    } t_tri;

    typedef struct packed {
        logic [IW-1:0]    idx;
        logic             hit;
        sth_pkg::t_reason reason;
        logic             last;
        logic [QW-1:0]    qid;
    } t_result;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [AW-1:0] paddr;
    logic [sth_pkg::DATA_W-1:0] pwdata, prdata;
    logic pready;
    logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;

    segment_triangle_hit_test #(.INDEX_WIDTH(IW)) u_dut (.*);

    // segment and settings as the predictor sees them
    logic signed [CW-1:0] seg_s [3];
    logic signed [CW-1:0] seg_e [3];
    logic [sth_pkg::THR_W-1:0] par_thresh;
    logic [QW-1:0] qry_id;

    t_result expected_results[$];
    int errors;
    int idle_cycles;
    bit wd_tripped;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // triple product u.(v x w), exact
    function automatic t_wide triple(t_wide u[3], t_wide v[3], t_wide w[3]);
        t_wide c0, c1, c2;
        c0 = v[1]*w[2] - v[2]*w[1];
        c1 = v[2]*w[0] - v[0]*w[2];
        c2 = v[0]*w[1] - v[1]*w[0];
        return u[0]*c0 + u[1]*c1 + u[2]*c2;
    endfunction

    function automatic int sgn(t_wide x);
        return (x < 0) ? -1 : ((x > 0) ? 1 : 0);
    endfunction

    function automatic sth_pkg::t_reason classify_triangle(t_tri t);
        t_wide v[3][3];
        t_wide d[3], a0[3], a1[3], a2[3];
        t_wide lo, hi, mx, mn, t01, t12, t20, den, num, aden, anum;
        int sd, sn;
        v[0][0] = t.ax; v[0][1] = t.ay; v[0][2] = t.az;
        v[1][0] = t.bx; v[1][1] = t.by; v[1][2] = t.bz;
        v[2][0] = t.cx; v[2][1] = t.cy; v[2][2] = t.cz;
        for (int k = 0; k < 3; k++) begin
            lo = (seg_s[k] < seg_e[k]) ? t_wide'(seg_s[k]) : t_wide'(seg_e[k]);
            hi = (seg_s[k] < seg_e[k]) ? t_wide'(seg_e[k]) : t_wide'(seg_s[k]);
            mx = v[0][k]; mn = v[0][k];
            for (int i = 1; i < 3; i++) begin
                if (v[i][k] > mx) mx = v[i][k];
                if (v[i][k] < mn) mn = v[i][k];
            end
            if (mx < lo || mn > hi) return sth_pkg::RSN_BOX_MISS;
        end
        for (int k = 0; k < 3; k++) begin
            d[k]  = t_wide'(seg_e[k]) - t_wide'(seg_s[k]);
            a0[k] = v[0][k] - t_wide'(seg_s[k]);
            a1[k] = v[1][k] - t_wide'(seg_s[k]);
            a2[k] = v[2][k] - t_wide'(seg_s[k]);
        end
        t01 = triple(d, a0, a1);
        t12 = triple(d, a1, a2);
        t20 = triple(d, a2, a0);
        den = t01 + t12 + t20;
        aden = (den < 0) ? -den : den;
        if (aden <= t_wide'({1'b0, par_thresh})) return sth_pkg::RSN_PARALLEL;
        sd = sgn(den);
        num = triple(a0, a1, a2);
        sn = sgn(num);
        anum = (num < 0) ? -num : num;
        if (sn != 0 && sn != sd) return sth_pkg::RSN_OUT_SEG;
        if (anum > aden) return sth_pkg::RSN_OUT_SEG;
        if (sgn(t01) == -sd || sgn(t12) == -sd || sgn(t20) == -sd)
            return sth_pkg::RSN_OUT_TRI;
        return sth_pkg::RSN_HIT;
    endfunction

    function automatic t_result predict_result(t_tri t);
        t_result r;
        r.idx    = t.idx;
        r.reason = classify_triangle(t);
        r.hit    = (r.reason == sth_pkg::RSN_HIT);
        r.last   = t.last;
        r.qid    = qry_id;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // apb write: setup then access, bus released by the caller
    task automatic reg_write(sth_pkg::t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            sth_pkg::REG_START_X: seg_s[0] = val;
            sth_pkg::REG_START_Y: seg_s[1] = val;
            sth_pkg::REG_START_Z: seg_s[2] = val;
            sth_pkg::REG_END_X:   seg_e[0] = val;
            sth_pkg::REG_END_Y:   seg_e[1] = val;
            sth_pkg::REG_END_Z:   seg_e[2] = val;
            sth_pkg::REG_THRESH:  par_thresh = val;
            default:              qry_id = val[QW-1:0];
        endcase
    endtask

    task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                               logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                               logic [31:0] thr, logic [15:0] qid);
        wait_drained();
        reg_write(sth_pkg::REG_START_X, sx);
        reg_write(sth_pkg::REG_START_Y, sy);
        reg_write(sth_pkg::REG_START_Z, sz);
        reg_write(sth_pkg::REG_END_X, ex);
        reg_write(sth_pkg::REG_END_Y, ey);
        reg_write(sth_pkg::REG_END_Z, ez);
        reg_write(sth_pkg::REG_THRESH, thr);
        reg_write(sth_pkg::REG_QUERY, 32'(qid));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // one triangle request, with a random gap between bursts
    int burst_left;
    task automatic send_triangle(t_tri t, bit have_want, t_result want);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t.cz, t.cy, t.cx, t.bz, t.by, t.bx, t.az, t.ay, t.ax, t.idx};
        s_axis_tlast  <= t.last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (have_want) begin
            want.qid = qry_id;
            expected_results.insert(expected_results.size(), want);
        end else begin
            expected_results.insert(expected_results.size(), predict_result(t));
        end
    endtask

    // receiver stall pattern
    int stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
            if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                w = expected_results.pop_front();
                if (m_axis_tdata[IW-1:0] !== w.idx)
                    report_mismatch("tri_index", m_axis_tdata[IW-1:0], w.idx);
                if (m_axis_tdata[IW +: QW] !== w.qid)
                    report_mismatch("query_id", m_axis_tdata[IW +: QW], w.qid);
                if (m_axis_tuser[0] !== w.hit)
                    report_mismatch("hit", m_axis_tuser[0], w.hit);
                if (m_axis_tuser[3:1] !== w.reason)
                    report_mismatch("reason", m_axis_tuser[3:1], w.reason);
                if (m_axis_tlast !== w.last)
                    report_mismatch("last", m_axis_tlast, w.last);
            end
        end
    end

    // watchdog on accepted requests
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT && !wd_tripped) begin
            wd_tripped = 1'b1;
            $display("watchdog timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
        endcase
    endfunction

    function automatic logic signed [31:0] near(logic signed [31:0] c, int spread);
        return c + 32'($signed($urandom_range(0, 2*spread)) - spread);
    endfunction

    // random triangle, mostly straddling a point of the segment
    function automatic t_tri rnd_triangle();
        t_tri t;
        logic signed [31:0] p[3];
        int spread;
        t.idx  = $urandom;
        t.last = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) < 2) begin
            {t.ax, t.ay, t.az} = {rnd_coord(), rnd_coord(), rnd_coord()};
            {t.bx, t.by, t.bz} = {rnd_coord(), rnd_coord(), rnd_coord()};
            {t.cx, t.cy, t.cz} = {rnd_coord(), rnd_coord(), rnd_coord()};
        end else begin
            for (int k = 0; k < 3; k++)
                p[k] = seg_s[k] + 32'((64'(seg_e[k]) - 64'(seg_s[k]))
                       * $signed(64'($urandom_range(0, 1200))) / 1000);
            spread = 1 << $urandom_range(4, 22);
            t.ax = near(p[0], spread); t.ay = near(p[1], spread); t.az = near(p[2], spread);
            t.bx = near(p[0], spread); t.by = near(p[1], spread); t.bz = near(p[2], spread);
            t.cx = near(p[0], spread); t.cy = near(p[1], spread); t.cz = near(p[2], spread);
            if ($urandom_range(0, 15) == 0) {t.cx, t.cy, t.cz} = {t.ax, t.ay, t.az};
        end
        return t;
    endfunction

    // directed table
    typedef struct {
        t_tri             tri_in;
        bit               have_want;
        sth_pkg::t_reason want_reason;
    } t_row;

    localparam logic signed [31:0] ONE = 32'sh10000;
    localparam logic signed [31:0] MAXC = 32'sh7fffffff;
    localparam logic signed [31:0] MINC = 32'sh80000000;

    t_row dir_rows[$];

    task automatic add_row(logic [15:0] idx, logic signed [31:0] ax, ay, az, bx, by, bz,
                           cx, cy, cz, logic last, bit hw, sth_pkg::t_reason r);
        t_row row;
        row.tri_in = '{idx, ax, ay, az, bx, by, bz, cx, cy, cz, last};
        row.have_want = hw;
        row.want_reason = r;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    initial begin
        t_result w;
        int n_rand;
        errors = 0; idle_cycles = 0; wd_tripped = 0; burst_left = 0; stall_mode = 1;
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tlast = 0;
        for (int k = 0; k < 3; k++) begin seg_s[k] = 0; seg_e[k] = 0; end
        par_thresh = 0; qry_id = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: zero-length segment at origin, so non-miss rows parallel
        add_row(16'h0000, -ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 0, 1,
                sth_pkg::RSN_PARALLEL);
        add_row(16'hffff, ONE, ONE, ONE, 2*ONE, ONE, ONE, ONE, 2*ONE, ONE, 1, 1,
                sth_pkg::RSN_BOX_MISS);
        foreach (dir_rows[i])
            send_triangle(dir_rows[i].tri_in, 1,
                          '{dir_rows[i].tri_in.idx,
                            dir_rows[i].want_reason == sth_pkg::RSN_HIT,
                            dir_rows[i].want_reason, dir_rows[i].tri_in.last, 0});
        dir_rows.delete();

        // segment along z from -1 to +1
        set_segment(0, 0, -ONE, 0, 0, ONE, 0, 16'h1234);
        add_row(1, -ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 0, 1, sth_pkg::RSN_HIT);
        // reversed winding
        add_row(2, -ONE, -ONE, 0, 0, ONE, 0, ONE, -ONE, 0, 0, 1, sth_pkg::RSN_HIT);
        // on a vertex
        add_row(3, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 1, sth_pkg::RSN_HIT);
        // on an edge
        add_row(4, -ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 1, sth_pkg::RSN_HIT);
        add_row(5, ONE, ONE, 0, 2*ONE, ONE, 0, ONE, 2*ONE, 0, 0, 1, sth_pkg::RSN_BOX_MISS);
        // at start
        add_row(6, -ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE, 0, 1, sth_pkg::RSN_HIT);
        // at end
        add_row(7, -ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 0, 1, sth_pkg::RSN_HIT);
        // in-plane
        add_row(8, -ONE, 0, -ONE, ONE, 0, -ONE, 0, 0, ONE, 0, 1, sth_pkg::RSN_PARALLEL);
        // degenerate
        add_row(9, -ONE, -ONE, 0, ONE, ONE, 0, -ONE, -ONE, 0, 0, 1, sth_pkg::RSN_PARALLEL);
        add_row(10, -ONE, -ONE, 0, ONE, -ONE, 0, ONE, 0, 0, 0, 1, sth_pkg::RSN_OUT_TRI);
        // tilted
        add_row(11, -ONE, -ONE, -ONE, ONE, -ONE, ONE, 0, ONE, ONE, 0, 0, sth_pkg::RSN_HIT);
        add_row(12, -ONE, -ONE, 2*ONE, ONE, -ONE, -ONE, 0, ONE, ONE, 0, 0, sth_pkg::RSN_HIT);
        add_row(13, MINC, MINC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, 0, 0,
                sth_pkg::RSN_HIT);
        add_row(14, MAXC, MAXC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, 1, 0,
                sth_pkg::RSN_HIT);
        foreach (dir_rows[i]) begin
            w = '{dir_rows[i].tri_in.idx, dir_rows[i].want_reason == sth_pkg::RSN_HIT,
                  dir_rows[i].want_reason, dir_rows[i].tri_in.last, 0};
            send_triangle(dir_rows[i].tri_in, dir_rows[i].have_want, w);
        end
        dir_rows.delete();

        // threshold at maximum; expected results come from the predictor
        set_segment(0, 0, -ONE, 0, 0, ONE, 32'hffffffff, 16'hffff);
        add_row(20, -ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 0, 0, sth_pkg::RSN_HIT);
        add_row(21, MINC, MINC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, 1, 0,
                sth_pkg::RSN_HIT);
        foreach (dir_rows[i])
            send_triangle(dir_rows[i].tri_in, 0, w);
        dir_rows.delete();

        // random phases over a range of segments
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: set_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom_range(0, 3) == 0 ? $urandom : 0, $urandom);
                1: set_segment(MINC, MINC, MINC, MAXC, MAXC, MAXC, $urandom, $urandom);
                default: set_segment(rnd_coord(), rnd_coord(), rnd_coord(),
                                     rnd_coord(), rnd_coord(), rnd_coord(),
                                     $urandom_range(0, 1) ? 0 : $urandom_range(0, 1 << 20),
                                     $urandom);
            endcase
            n_rand = 150 + $urandom_range(0, 10);
            repeat (n_rand) send_triangle(rnd_triangle(), 0, w);
        end

        wait_drained();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sth_pkg.sv
rtl/segment_triangle_hit_test.sv
tb/tb_segment_triangle_hit_test.sv
